// ===== rtl/core/gni_pkg.sv =====
// ----------------------------------------------------------------------------
// gni_pkg
// Shared constants, types and codes of the greedy NMS block.
// ----------------------------------------------------------------------------
package gni_pkg;

    // Sizing of the box store and of the coordinates.
    localparam int MAX_BOXES  = 128;
    localparam int COORD_BITS = 16;

    // Field widths that the interface fixes.
    localparam int FIELD_W = 16;
    localparam int SCORE_W = 16;
    localparam int THR_W   = 16;
    localparam int RIDX_W  = 7;
    localparam int SURV_W  = 8;

    // Derived widths.
    localparam int IDX_W  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W  = $clog2(MAX_BOXES + 1);
    localparam int GEOM_W = 4 * COORD_BITS;
    localparam int OW_W   = COORD_BITS + 4;
    localparam int AREA_W = 2 * COORD_BITS;
    localparam int U_W    = 2 * COORD_BITS + 4;
    localparam int CMP_W  = THR_W + U_W;

    // Reset value of the IoU threshold (0.5 in Q0.16).
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(32768);

    // Operation and response codes.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_READ   = 1'b1;
    localparam logic RESP_DONE = 1'b0;
    localparam logic RESP_READ = 1'b1;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
    } t_geom;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic read;
        logic run_init;
        logic scan_start;
        logic scan_find;
        logic scan_supp;
        logic best_rd;
        logic best_latch;
        logic best_area;
        logic resp_read;
        logic resp_done;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic found;
    } t_dp_status;

endpackage

// ===== rtl/core/gni_ram.sv =====
// ----------------------------------------------------------------------------
// gni_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gni_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/core/gni_iou.sv =====
// ----------------------------------------------------------------------------
// gni_iou
// Pipelined IoU test of one candidate box against the current best box.
// ----------------------------------------------------------------------------
module gni_iou
    import gni_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [IDX_W-1:0]   i_addr,
    input  logic               i_elig,
    input  t_geom              i_geom,
    input  t_geom              i_best,
    input  logic [AREA_W-1:0]  i_barea,
    input  logic [THR_W-1:0]   i_thr,
    output logic               o_valid,
    output logic [IDX_W-1:0]   o_addr,
    output logic               o_hit,
    output logic               o_busy
);

    // Doubled overlap of two intervals given by center and size.
    function automatic logic signed [OW_W-1:0] f_overlap(
        input logic [COORD_BITS-1:0] c1,
        input logic [COORD_BITS-1:0] s1,
        input logic [COORD_BITS-1:0] c2,
        input logic [COORD_BITS-1:0] s2
    );
        logic signed [OW_W-1:0] l1;
        logic signed [OW_W-1:0] r1;
        logic signed [OW_W-1:0] l2;
        logic signed [OW_W-1:0] r2;
        logic signed [OW_W-1:0] lft;
        logic signed [OW_W-1:0] rgt;
        l1  = $signed(OW_W'({c1, 1'b0})) - $signed(OW_W'(s1));
        r1  = $signed(OW_W'({c1, 1'b0})) + $signed(OW_W'(s1));
        l2  = $signed(OW_W'({c2, 1'b0})) - $signed(OW_W'(s2));
        r2  = $signed(OW_W'({c2, 1'b0})) + $signed(OW_W'(s2));
        lft = (l1 > l2) ? l1 : l2;
        rgt = (r1 < r2) ? r1 : r2;
        return rgt - lft;
    endfunction

    logic [4:0]                      r_v;
    logic [IDX_W-1:0]                r_a [5];
    logic [4:0]                      r_e;
    logic signed [OW_W-1:0]          r_ow;
    logic signed [OW_W-1:0]          r_oh;
    logic [AREA_W-1:0]               r_area;
    logic [U_W-1:0]                  r_i4_b;
    logic [AREA_W:0]                 r_asum;
    logic [U_W-1:0]                  r_i4_c;
    logic [U_W-1:0]                  r_u4;
    logic [CMP_W-1:0]                r_lhs;
    logic [CMP_W-1:0]                r_rhs;
    logic                            r_hit;

    // Valid and tag chain, one entry per stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_a[0] <= i_addr;
        r_e[0] <= i_elig;
        for (int k = 1; k < 5; k++) begin
            r_a[k] <= r_a[k-1];
            r_e[k] <= r_e[k-1];
        end
    end

    // Stage 1: overlaps per axis and the candidate's area.
    always_ff @(posedge i_clk) begin
        r_ow   <= f_overlap(i_best.x, i_best.w, i_geom.x, i_geom.w);
        r_oh   <= f_overlap(i_best.y, i_best.h, i_geom.y, i_geom.h);
        r_area <= i_geom.w * i_geom.h;
    end

    // Stage 2: intersection product and area sum.
    always_ff @(posedge i_clk) begin
        if (r_ow[OW_W-1] || r_oh[OW_W-1]) begin
            r_i4_b <= '0;
        end else begin
            r_i4_b <= U_W'(r_ow[COORD_BITS+1:0]) * U_W'(r_oh[COORD_BITS+1:0]);
        end
        r_asum <= (AREA_W+1)'(i_barea) + (AREA_W+1)'(r_area);
    end

    // Stage 3: union, scaled by four.
    always_ff @(posedge i_clk) begin
        r_u4   <= U_W'({r_asum, 2'b00}) - r_i4_b;
        r_i4_c <= r_i4_b;
    end

    // Stage 4: scale both sides of the comparison.
    always_ff @(posedge i_clk) begin
        r_rhs <= CMP_W'(i_thr) * CMP_W'(r_u4);
        r_lhs <= CMP_W'({r_i4_c, {THR_W{1'b0}}});
    end

    // Stage 5: compare.
    always_ff @(posedge i_clk) begin
        r_hit <= r_e[3] && (r_lhs > r_rhs);
    end

    assign o_valid = r_v[4];
    assign o_addr  = r_a[4];
    assign o_hit   = r_hit && r_e[4];
    assign o_busy  = |r_v;

endmodule

// ===== rtl/core/gni_dp.sv =====
// ----------------------------------------------------------------------------
// gni_dp
// Datapath: box and score stores, scan counter, best search and suppression.
// ----------------------------------------------------------------------------
module gni_dp
    import gni_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctrl_cmd          i_cmd,
    output t_dp_status         o_status,
    input  logic               i_cfg_we,
    input  logic [THR_W-1:0]   i_cfg_wdata,
    input  logic [FIELD_W-1:0] i_box_x,
    input  logic [FIELD_W-1:0] i_box_y,
    input  logic [FIELD_W-1:0] i_box_w,
    input  logic [FIELD_W-1:0] i_box_h,
    input  logic [SCORE_W-1:0] i_score,
    input  logic [RIDX_W-1:0]  i_read_index,
    output logic               o_response_kind,
    output logic [SCORE_W-1:0] o_final_score,
    output logic               o_kept,
    output logic [SURV_W-1:0]  o_survivors,
    output logic               o_index_in_range
);

    logic [THR_W-1:0]     r_thr;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_surv;
    logic                 r_closed;
    logic                 r_rd_in;
    logic                 r_pick_v;
    logic [SCORE_W-1:0]   r_pick_score;
    logic [IDX_W-1:0]     r_pick_idx;
    logic [CNT_W-1:0]     r_idx;
    logic                 r_vf;
    logic                 r_vs;
    logic [IDX_W-1:0]     r_a1;
    logic [IDX_W-1:0]     r_best;
    logic [SCORE_W-1:0]   r_best_score;
    logic                 r_found;
    t_geom                r_bgeom;
    logic [AREA_W-1:0]    r_barea;

    logic [CNT_W-1:0]     eff_cnt;
    logic [CNT_W-1:0]     eff_surv;
    logic                 load_ok;
    logic                 issue;
    logic [IDX_W-1:0]     scan_addr;
    logic                 s_we;
    logic [IDX_W-1:0]     s_waddr;
    logic [SCORE_W-1:0]   s_wdata;
    logic [IDX_W-1:0]     s_raddr;
    logic [SCORE_W-1:0]   s_rdata;
    logic [IDX_W-1:0]     g_raddr;
    logic [GEOM_W-1:0]    g_rdata;
    logic [GEOM_W-1:0]    g_wdata;
    logic                 iou_valid;
    logic [IDX_W-1:0]     iou_addr;
    logic                 iou_hit;
    logic                 iou_busy;
    logic                 supp_wr;
    logic                 rd_in;
    logic                 visited_a1;

    // A load into a closed batch starts a new one.
    assign eff_cnt   = r_closed ? '0 : r_count;
    assign eff_surv  = r_closed ? '0 : r_surv;
    assign load_ok   = eff_cnt < CNT_W'(MAX_BOXES);
    assign scan_addr = r_idx[IDX_W-1:0];
    assign issue     = (i_cmd.scan_find || i_cmd.scan_supp) && (r_idx < r_count);
    assign supp_wr   = iou_valid && iou_hit;
    assign rd_in     = (CNT_W+RIDX_W)'(i_read_index) < (CNT_W+RIDX_W)'(r_count);

    // Boxes are picked in falling rank order and a picked box keeps its score,
    // so a box has been visited exactly when it is nonzero and ranks at or
    // above the last pick (higher score, or equal score and lower index).
    assign visited_a1 = r_pick_v && (s_rdata != '0) &&
                        ((s_rdata > r_pick_score) ||
                         ((s_rdata == r_pick_score) && (r_a1 <= r_pick_idx)));

    // Score store port selection.
    assign s_we    = (i_cmd.load && load_ok) || supp_wr;
    assign s_waddr = i_cmd.load ? eff_cnt[IDX_W-1:0] : iou_addr;
    assign s_wdata = i_cmd.load ? i_score : '0;
    assign s_raddr = i_cmd.read ? IDX_W'(i_read_index) : scan_addr;

    // Geometry store port selection.
    assign g_wdata = {i_box_x[COORD_BITS-1:0], i_box_y[COORD_BITS-1:0],
                      i_box_w[COORD_BITS-1:0], i_box_h[COORD_BITS-1:0]};
    assign g_raddr = i_cmd.best_rd ? r_best : scan_addr;

    gni_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_BOXES)) u_score_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    gni_ram #(.WIDTH(GEOM_W), .DEPTH(MAX_BOXES)) u_geom_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && load_ok),
        .i_waddr (eff_cnt[IDX_W-1:0]),
        .i_wdata (g_wdata),
        .i_raddr (g_raddr),
        .o_rdata (g_rdata)
    );

    gni_iou u_iou (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vs),
        .i_addr  (r_a1),
        .i_elig  (!visited_a1 && (s_rdata != '0)),
        .i_geom  (t_geom'(g_rdata)),
        .i_best  (r_bgeom),
        .i_barea (r_barea),
        .i_thr   (r_thr),
        .o_valid (iou_valid),
        .o_addr  (iou_addr),
        .o_hit   (iou_hit),
        .o_busy  (iou_busy)
    );

    // Threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // Batch bookkeeping: count, survivors and the closed flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_surv   <= '0;
            r_closed <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_count  <= load_ok ? eff_cnt + CNT_W'(1) : eff_cnt;
                r_surv   <= eff_surv + CNT_W'(load_ok && (i_score != '0));
                r_closed <= 1'b0;
            end else if (supp_wr) begin
                r_surv <= r_surv - CNT_W'(1);
            end
            if (i_cmd.resp_done) begin
                r_closed <= 1'b1;
            end
        end
    end

    // Range check of a read, held for the response cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_in <= rd_in;
        end
    end

    // Last picked box, which stands for the set of visited boxes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pick_v     <= 1'b0;
            r_pick_score <= '0;
            r_pick_idx   <= '0;
        end else if (i_cmd.run_init) begin
            r_pick_v <= 1'b0;
        end else if (i_cmd.best_rd) begin
            r_pick_v     <= 1'b1;
            r_pick_score <= r_best_score;
            r_pick_idx   <= r_best;
        end
    end

    // Scan counter and read-return flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_vf  <= 1'b0;
            r_vs  <= 1'b0;
        end else begin
            r_vf <= issue && i_cmd.scan_find;
            r_vs <= issue && i_cmd.scan_supp;
            if (i_cmd.scan_start) begin
                r_idx <= '0;
            end else if (issue) begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a1 <= scan_addr;
    end

    // Best search: strictly greater keeps the lower index on ties.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found      <= 1'b0;
            r_best_score <= '0;
            r_best       <= '0;
        end else if (i_cmd.scan_start) begin
            r_found      <= 1'b0;
            r_best_score <= '0;
        end else if (r_vf && !visited_a1 && (s_rdata > r_best_score)) begin
            r_found      <= 1'b1;
            r_best_score <= s_rdata;
            r_best       <= r_a1;
        end
    end

    // Best box geometry and its area.
    always_ff @(posedge i_clk) begin
        if (i_cmd.best_latch) begin
            r_bgeom <= t_geom'(g_rdata);
        end
        if (i_cmd.best_area) begin
            r_barea <= r_bgeom.w * r_bgeom.h;
        end
    end

    assign o_status.scan_done = !(r_idx < r_count) && !r_vf && !r_vs && !iou_busy;
    assign o_status.found     = r_found;

    // Response fields.
    assign o_response_kind  = i_cmd.resp_read ? RESP_READ : RESP_DONE;
    assign o_index_in_range = i_cmd.resp_read && r_rd_in;
    assign o_final_score    = o_index_in_range ? s_rdata : '0;
    assign o_kept           = o_final_score != '0;
    assign o_survivors      = SURV_W'(r_surv);

endmodule

// ===== rtl/core/gni_ctrl.sv =====
// ----------------------------------------------------------------------------
// gni_ctrl
// Controller state machine: command decode, run sequencing and responses.
// ----------------------------------------------------------------------------
module gni_ctrl
    import gni_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic       i_operation,
    input  logic       i_last_box,
    output logic       busy,
    output logic       o_valid,
    output t_ctrl_cmd  o_cmd,
    input  t_dp_status i_status
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_INIT  = 4'd2;
    localparam logic [3:0] S_FIND  = 4'd3;
    localparam logic [3:0] S_BRD   = 4'd4;
    localparam logic [3:0] S_BLAT  = 4'd5;
    localparam logic [3:0] S_BAREA = 4'd6;
    localparam logic [3:0] S_SUPP  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       accept;

    assign busy   = r_state != S_IDLE;
    assign accept = start && !busy;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_operation == OP_READ) begin
                        o_cmd.read = 1'b1;
                        n_state    = S_READ;
                    end else begin
                        o_cmd.load = 1'b1;
                        if (i_last_box) begin
                            n_state = S_INIT;
                        end
                    end
                end
            end
            S_READ: begin
                o_cmd.resp_read = 1'b1;
                n_state         = S_IDLE;
            end
            S_INIT: begin
                o_cmd.run_init   = 1'b1;
                o_cmd.scan_start = 1'b1;
                n_state          = S_FIND;
            end
            S_FIND: begin
                o_cmd.scan_find = 1'b1;
                if (i_status.scan_done) begin
                    n_state = i_status.found ? S_BRD : S_DONE;
                end
            end
            S_BRD: begin
                o_cmd.best_rd = 1'b1;
                n_state       = S_BLAT;
            end
            S_BLAT: begin
                o_cmd.best_latch = 1'b1;
                n_state          = S_BAREA;
            end
            S_BAREA: begin
                o_cmd.best_area  = 1'b1;
                o_cmd.scan_start = 1'b1;
                n_state          = S_SUPP;
            end
            S_SUPP: begin
                o_cmd.scan_supp = 1'b1;
                if (i_status.scan_done) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_FIND;
                end
            end
            S_DONE: begin
                o_cmd.resp_done = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_valid = (r_state == S_READ) || (r_state == S_DONE);

    // A response strobe is never held high back to back.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("response strobe held for two cycles");

    // An accepted read answers in the following cycle.
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_operation == OP_READ)) |=> (o_valid && o_cmd.resp_read))
        else $error("read response missing");

    // A run only finishes from a search that found no box.
    a_done_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> ($past(r_state) == S_FIND && !$past(i_status.found)))
        else $error("run finished outside a failed search");

endmodule

// ===== rtl/core/greedy_nms_iou.sv =====
// ----------------------------------------------------------------------------
// greedy_nms_iou
// Greedy non-maximum suppression of one class with an exact IoU test.
// ----------------------------------------------------------------------------
// Usage: a command is transferred when start is high and busy is low.
// A load (i_operation 0) stores one box and score and leaves busy low, so
// loads can follow back to back. A load with i_last_box set also starts
// the suppression run; busy then stays high until the run response
// (o_response_kind 0, survivors count) is shown with o_valid. A read
// (i_operation 1) returns one box's final score in the next cycle; the
// block is busy for that response cycle. A run repeats a best search over
// the boxes and, after each pick, a best fetch and a suppression scan
// through the five-stage IoU pipeline, until a search finds no box; the
// score store has a single read port. Each response is shown for exactly
// one cycle and cannot be stalled. Reset clears the batch count and the
// last pick and sets the threshold to 0.5; the stores need no clearing
// pass. The threshold is written through i_cfg_we and i_cfg_wdata; the
// user must do so only while the block is idle, which the block itself
// does not enforce.
// ----------------------------------------------------------------------------
module greedy_nms_iou
    import gni_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [THR_W-1:0]   i_cfg_wdata,
    input  logic               i_operation,
    input  logic [FIELD_W-1:0] i_box_x,
    input  logic [FIELD_W-1:0] i_box_y,
    input  logic [FIELD_W-1:0] i_box_w,
    input  logic [FIELD_W-1:0] i_box_h,
    input  logic [SCORE_W-1:0] i_score,
    input  logic               i_last_box,
    input  logic [RIDX_W-1:0]  i_read_index,
    output logic               o_valid,
    output logic               o_response_kind,
    output logic [SCORE_W-1:0] o_final_score,
    output logic               o_kept,
    output logic [SURV_W-1:0]  o_survivors,
    output logic               o_index_in_range
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    gni_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_operation),
        .i_last_box  (i_last_box),
        .busy        (busy),
        .o_valid     (o_valid),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    gni_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_box_x          (i_box_x),
        .i_box_y          (i_box_y),
        .i_box_w          (i_box_w),
        .i_box_h          (i_box_h),
        .i_score          (i_score),
        .i_read_index     (i_read_index),
        .o_response_kind  (o_response_kind),
        .o_final_score    (o_final_score),
        .o_kept           (o_kept),
        .o_survivors      (o_survivors),
        .o_index_in_range (o_index_in_range)
    );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the greedy NMS block. A queue of load, read and
// threshold-write commands is driven in random bursts. A local model of the
// box store and of the suppression run predicts each response, and the
// monitor compares every response with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import gni_pkg::*;

    localparam int ITEM_TARGET  = 700;
    localparam int SETTLE       = 8;
    localparam int IDLE_LIMIT   = 400000;
    localparam int END_PAUSE    = 40;

    typedef enum logic {ITEM_CMD, ITEM_CFG} item_kind_e;

    typedef struct {
        item_kind_e          kind;
        logic                op;
        logic [FIELD_W-1:0]  x, y, w, h;
        logic [SCORE_W-1:0]  score;
        logic                last;
        logic [RIDX_W-1:0]   ridx;
        logic [THR_W-1:0]    thr;
    } pending_t;

    typedef struct {
        logic               kind;
        logic [SCORE_W-1:0] final_score;
        logic               kept;
        logic [SURV_W-1:0]  survivors;
        logic               in_range;
    } response_t;

    // Block ports.
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_cfg_we = 1'b0;
    logic [THR_W-1:0]   i_cfg_wdata = '0;
    logic               i_operation = OP_LOAD;
    logic [FIELD_W-1:0] i_box_x = '0;
    logic [FIELD_W-1:0] i_box_y = '0;
    logic [FIELD_W-1:0] i_box_w = '0;
    logic [FIELD_W-1:0] i_box_h = '0;
    logic [SCORE_W-1:0] i_score = '0;
    logic               i_last_box = 1'b0;
    logic [RIDX_W-1:0]  i_read_index = '0;
    logic               o_valid;
    logic               o_response_kind;
    logic [SCORE_W-1:0] o_final_score;
    logic               o_kept;
    logic [SURV_W-1:0]  o_survivors;
    logic               o_index_in_range;

    greedy_nms_iou u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_operation      (i_operation),
        .i_box_x          (i_box_x),
        .i_box_y          (i_box_y),
        .i_box_w          (i_box_w),
        .i_box_h          (i_box_h),
        .i_score          (i_score),
        .i_last_box       (i_last_box),
        .i_read_index     (i_read_index),
        .o_valid          (o_valid),
        .o_response_kind  (o_response_kind),
        .o_final_score    (o_final_score),
        .o_kept           (o_kept),
        .o_survivors      (o_survivors),
        .o_index_in_range (o_index_in_range)
    );

    // Clock.
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Reset at the start of the run.
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    pending_t  command_queue[$];
    response_t awaited_responses[$];
    int        error_count = 0;
    int        item_total  = 0;

    // Local copy of the block state.
    logic [THR_W-1:0]   iou_limit = THR_RESET;
    t_geom              box_geom[MAX_BOXES];
    logic [SCORE_W-1:0] box_score[MAX_BOXES];
    int                 box_count = 0;
    bit                 batch_done = 1'b0;

    // Exact IoU test with doubled edges, compared without division.
    function automatic bit iou_over_limit(t_geom a, t_geom b);
        longint l1, r1, l2, r2, ow, oh;
        longint unsigned i4, u4;
        logic [95:0] lhs, rhs;
        // All edge arithmetic is signed so that negative left edges compare right.
        l1 = 2 * longint'(a.x) - longint'(a.w);
        r1 = 2 * longint'(a.x) + longint'(a.w);
        l2 = 2 * longint'(b.x) - longint'(b.w);
        r2 = 2 * longint'(b.x) + longint'(b.w);
        ow = ((r1 < r2) ? r1 : r2) - ((l1 > l2) ? l1 : l2);
        l1 = 2 * longint'(a.y) - longint'(a.h);
        r1 = 2 * longint'(a.y) + longint'(a.h);
        l2 = 2 * longint'(b.y) - longint'(b.h);
        r2 = 2 * longint'(b.y) + longint'(b.h);
        oh = ((r1 < r2) ? r1 : r2) - ((l1 > l2) ? l1 : l2);
        i4 = (ow >= 0 && oh >= 0) ? $unsigned(ow * oh) : 64'd0;
        u4 = $unsigned(4 * longint'(a.w) * longint'(a.h) +
                       4 * longint'(b.w) * longint'(b.h) - $signed(i4));
        lhs = 96'(i4) << 16;
        rhs = 96'(iou_limit) * 96'(u4);
        return lhs > rhs;
    endfunction

    function automatic logic [SURV_W-1:0] surviving_boxes();
        int n = 0;
        for (int i = 0; i < box_count; i++)
            if (box_score[i] != 0) n++;
        return SURV_W'(n);
    endfunction

    // Greedy pass: highest score first, lower index on ties.
    function automatic void suppress_overlaps();
        bit visited[MAX_BOXES];
        int best;
        logic [SCORE_W-1:0] best_score;
        for (int i = 0; i < MAX_BOXES; i++) visited[i] = 1'b0;
        forever begin
            best = -1;
            best_score = '0;
            for (int i = 0; i < box_count; i++) begin
                if (!visited[i] && box_score[i] > best_score) begin
                    best = i;
                    best_score = box_score[i];
                end
            end
            if (best < 0) break;
            visited[best] = 1'b1;
            for (int i = 0; i < box_count; i++) begin
                if (!visited[i] && box_score[i] != 0 &&
                    iou_over_limit(box_geom[best], box_geom[i]))
                    box_score[i] = '0;
            end
        end
    endfunction

    // Update the local state for one accepted command and queue its response.
    function automatic void apply_command(pending_t c);
        response_t r;
        if (c.op == OP_LOAD) begin
            if (batch_done) begin
                box_count = 0;
                batch_done = 1'b0;
            end
            if (box_count < MAX_BOXES) begin
                box_geom[box_count].x = c.x[COORD_BITS-1:0];
                box_geom[box_count].y = c.y[COORD_BITS-1:0];
                box_geom[box_count].w = c.w[COORD_BITS-1:0];
                box_geom[box_count].h = c.h[COORD_BITS-1:0];
                box_score[box_count] = c.score;
                box_count++;
            end
            if (!c.last) return;
            suppress_overlaps();
            batch_done = 1'b1;
            r.kind = RESP_DONE;
            r.final_score = '0;
            r.kept = 1'b0;
            r.in_range = 1'b0;
        end else begin
            r.kind = RESP_READ;
            if (int'(c.ridx) < box_count) begin
                r.final_score = box_score[c.ridx];
                r.kept = box_score[c.ridx] != 0;
                r.in_range = 1'b1;
            end else begin
                r.final_score = '0;
                r.kept = 1'b0;
                r.in_range = 1'b0;
            end
        end
        r.survivors = surviving_boxes();
        awaited_responses.push_back(r);
    endfunction

    // Stimulus builders.
    task automatic add_load(int x, int y, int w, int h, int s, bit last);
        pending_t c;
        c.kind = ITEM_CMD;
        c.op = OP_LOAD;
        c.x = FIELD_W'(x); c.y = FIELD_W'(y); c.w = FIELD_W'(w); c.h = FIELD_W'(h);
        c.score = SCORE_W'(s);
        c.last = last;
        c.ridx = RIDX_W'($urandom);
        c.thr = '0;
        command_queue.push_back(c);
        item_total++;
    endtask

    task automatic add_read(int idx);
        pending_t c;
        c.kind = ITEM_CMD;
        c.op = OP_READ;
        c.x = FIELD_W'($urandom); c.y = FIELD_W'($urandom);
        c.w = FIELD_W'($urandom); c.h = FIELD_W'($urandom);
        c.score = SCORE_W'($urandom);
        c.last = 1'($urandom);
        c.ridx = RIDX_W'(idx);
        c.thr = '0;
        command_queue.push_back(c);
        item_total++;
    endtask

    task automatic add_threshold(int v);
        pending_t c;
        c.kind = ITEM_CFG;
        c.op = OP_LOAD;
        c.x = '0; c.y = '0; c.w = '0; c.h = '0;
        c.score = '0;
        c.last = 1'b0;
        c.ridx = '0;
        c.thr = THR_W'(v);
        command_queue.push_back(c);
    endtask

    // One batch of boxes clustered around a random point, so overlaps happen.
    task automatic add_batch(int n, bit reads_inside);
        int cx, cy, spread, s;
        cx = $urandom_range(0, 65535);
        cy = $urandom_range(0, 65535);
        spread = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(16, 4096);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
                0: s = 0;
                1: s = $urandom_range(1, 3) * 16384;
                default: s = $urandom_range(1, 65535);
            endcase
            if (reads_inside && $urandom_range(0, 4) == 0)
                add_read($urandom_range(0, n));
            add_load(cx + $urandom_range(0, spread) - spread / 2,
                     cy + $urandom_range(0, spread) - spread / 2,
                     ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 65535) >>
                         $urandom_range(0, 4),
                     ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 65535) >>
                         $urandom_range(0, 4),
                     s, i == n - 1);
        end
    endtask

    // Build the command list.
    initial begin
        // Directed: empty read, extreme boxes, ties, zero area, zero score.
        add_read(0);
        add_load(16'h8000, 16'h8000, 16'h4000, 16'h4000, 16'hFFFF, 1'b0);
        add_load(16'h8100, 16'h8000, 16'h4000, 16'h4000, 16'hFFFF, 1'b0);
        add_load(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0001, 1'b0);
        add_load(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 1'b0);
        add_load(16'h2000, 16'h2000, 16'h0000, 16'h0000, 16'h4000, 1'b0);
        add_load(16'h2000, 16'h2000, 16'h0000, 16'h0000, 16'h4000, 1'b0);
        add_load(16'h8000, 16'h8000, 16'h4000, 16'h4000, 16'h0000, 1'b0);
        add_read(2);
        add_read(127);
        add_load(16'h7F00, 16'h8080, 16'h3000, 16'h5000, 16'hC000, 1'b1);
        for (int i = 0; i < 9; i++) add_read(i);
        add_read(127);

        // Threshold extremes on identical boxes.
        add_threshold(0);
        for (int i = 0; i < 3; i++)
            add_load(16'h4000, 16'h4000, 16'h1000, 16'h1000, 16'h1000 * (i + 1), i == 2);
        for (int i = 0; i < 3; i++) add_read(i);
        add_threshold(16'hFFFF);
        for (int i = 0; i < 3; i++)
            add_load(16'h4000, 16'h4000, 16'h1000, 16'h1000, 16'h2000, i == 2);
        for (int i = 0; i < 4; i++) add_read(i);

        // Full store: loads past the limit are dropped, the last still runs.
        add_threshold(THR_RESET);
        add_batch(MAX_BOXES + 2, 1'b0);
        add_read(0);
        add_read(MAX_BOXES - 1);

        // Random phases: mostly complete batches, then reads.
        while (item_total < ITEM_TARGET) begin
            int n;
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0: add_threshold(0);
                    1: add_threshold(16'hFFFF);
                    default: add_threshold($urandom_range(0, 65535));
                endcase
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            add_batch(n, $urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, n + 3)) begin
                if ($urandom_range(0, 7) == 0) add_read($urandom_range(0, 127));
                else add_read($urandom_range(0, n + 1));
            end
        end
    end

    // Driver: bursts of commands, threshold writes only while idle.
    pending_t drive_item;
    int gap_left = 0;
    int burst_left = 1;
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        pending_t nxt;
        bit fire;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_we <= 1'b0;
        end else begin
            fire = start && !busy;
            if (fire) apply_command(drive_item);
            if (o_valid || start) quiet_cycles = 0;
            else quiet_cycles++;

            if (start && !fire) begin
                i_cfg_we <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
                i_cfg_we <= 1'b0;
            end else if (command_queue.size() == 0) begin
                start <= 1'b0;
                i_cfg_we <= 1'b0;
            end else if (command_queue[0].kind == ITEM_CFG) begin
                start <= 1'b0;
                if (awaited_responses.size() == 0 && !busy && !i_cfg_we &&
                    quiet_cycles >= SETTLE) begin
                    nxt = command_queue.pop_front();
                    i_cfg_we <= 1'b1;
                    i_cfg_wdata <= nxt.thr;
                    iou_limit = nxt.thr;
                end else begin
                    i_cfg_we <= 1'b0;
                end
            end else begin
                nxt = command_queue.pop_front();
                drive_item = nxt;
                start <= 1'b1;
                i_cfg_we <= 1'b0;
                i_operation <= nxt.op;
                i_box_x <= nxt.x;
                i_box_y <= nxt.y;
                i_box_w <= nxt.w;
                i_box_h <= nxt.h;
                i_score <= nxt.score;
                i_last_box <= nxt.last;
                i_read_index <= nxt.ridx;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end
            end
        end
    end

    task automatic report_error(string field, int got, int want);
        $display("ERROR at %0t: %s is %0d, predicted %0d", $realtime, field, got, want);
        error_count++;
    endtask

    // Monitor: every response transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        response_t r;
        if (i_rst_n && o_valid) begin
            if (awaited_responses.size() == 0) begin
                report_error("unpredicted response kind", o_response_kind, -1);
            end else begin
                r = awaited_responses.pop_front();
                if (o_response_kind !== r.kind)
                    report_error("response_kind", o_response_kind, r.kind);
                if (o_final_score !== r.final_score)
                    report_error("final_score", o_final_score, r.final_score);
                if (o_kept !== r.kept)
                    report_error("kept", o_kept, r.kept);
                if (o_survivors !== r.survivors)
                    report_error("survivors", o_survivors, r.survivors);
                if (o_index_in_range !== r.in_range)
                    report_error("index_in_range", o_index_in_range, r.in_range);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid || i_cfg_we) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // End of run: drain all predictions, let the block settle, then report.
    initial begin
        @(posedge i_clk);
        while (command_queue.size() != 0 || start || awaited_responses.size() != 0)
            @(posedge i_clk);
        repeat (END_PAUSE) @(posedge i_clk);
        if (error_count == 0 && awaited_responses.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
